// ===== rtl/cpu8alu_pkg.sv =====
// Shared types and operation codes for the 8-bit CPU ALU with flags.
// Used by the ALU top level and its port checker; no dependencies.

package cpu8alu_pkg;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_ADC   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_SBC   = 4'd3;
  localparam logic [3:0] OP_AND   = 4'd4;
  localparam logic [3:0] OP_XOR   = 4'd5;
  localparam logic [3:0] OP_OR    = 4'd6;
  localparam logic [3:0] OP_CP    = 4'd7;
  localparam logic [3:0] OP_INC   = 4'd8;
  localparam logic [3:0] OP_DEC   = 4'd9;
  localparam logic [3:0] OP_SWAP  = 4'd10;
  localparam logic [3:0] OP_ADD16 = 4'd11;

  // Flag bit positions: Z N H C
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // Pipeline depth from accepted command to result strobe
  localparam int LATENCY = 3;

  typedef struct packed {
    logic [3:0]  operation;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [3:0]  flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        writes_result;
  } alu_out_t;

  // Second stage: low byte of the adder done, high byte still to go
  typedef struct packed {
    logic [3:0] operation;
    logic [7:0] x_hi;
    logic [7:0] y_hi;
    logic [8:0] sum_lo;
    logic       h4;
    logic [7:0] logic_res;
    logic [3:0] flags_in;
  } alu_mid_t;

endpackage

// ===== rtl/cpu8_alu_with_flags.sv =====
// 8-bit CPU ALU with Z/N/H/C flags, three-stage pipeline.
// Depends on cpu8alu_pkg for payload structs and operation codes.
//
// Usage: one command is taken in every cycle at which start is high; busy is
// always low, since nothing inside ever holds off. Each command produces one
// result, shown for one cycle under out_valid. The work is split as input
// register, low-byte add plus logic ops, then high-byte add and flag assembly
// into the output register, and throughput is one operation per clock. The
// result strobe cannot be stalled by the receiver.

module cpu8_alu_with_flags (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  cpu8alu_pkg::alu_in_t  in_item,
  output logic                  out_valid,
  output cpu8alu_pkg::alu_out_t out_item
);

  logic                  v1_r;
  cpu8alu_pkg::alu_in_t  in1_r;
  logic                  v2_r;
  cpu8alu_pkg::alu_mid_t mid_r;
  cpu8alu_pkg::alu_mid_t mid_nxt;
  logic                  out_valid_r;
  cpu8alu_pkg::alu_out_t out_item_r;
  cpu8alu_pkg::alu_out_t out_item_nxt;

  assign busy = 1'b0;

  // Stage 1: capture the command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    in1_r <= in_item;
  end

  // Stage 2: operand select, low-byte add, logic ops
  always_comb begin
    logic [7:0] a8;
    logic [7:0] b8;
    logic [7:0] x_lo;
    logic [7:0] y_lo;
    logic       ci;
    logic       cin;
    logic [4:0] nib;

    a8   = in1_r.operand_a[7:0];
    b8   = in1_r.operand_b[7:0];
    cin  = in1_r.flags_in[cpu8alu_pkg::FLAG_C];
    x_lo = a8;
    y_lo = 8'h00;
    ci   = 1'b0;
    mid_nxt.x_hi      = 8'h00;
    mid_nxt.y_hi      = 8'h00;
    mid_nxt.logic_res = 8'h00;

    case (in1_r.operation)
      cpu8alu_pkg::OP_ADD: begin
        y_lo = b8;
      end
      cpu8alu_pkg::OP_ADC: begin
        y_lo = b8;
        ci   = cin;
      end
      cpu8alu_pkg::OP_SUB, cpu8alu_pkg::OP_CP: begin
        y_lo = ~b8;
        ci   = 1'b1;
      end
      cpu8alu_pkg::OP_SBC: begin
        y_lo = ~b8;
        ci   = ~cin;
      end
      cpu8alu_pkg::OP_INC: begin
        ci = 1'b1;
      end
      cpu8alu_pkg::OP_DEC: begin
        // a + 0xFF: borrow out of the nibble shows as a missing carry
        y_lo = 8'hFF;
      end
      cpu8alu_pkg::OP_AND:  mid_nxt.logic_res = a8 & b8;
      cpu8alu_pkg::OP_XOR:  mid_nxt.logic_res = a8 ^ b8;
      cpu8alu_pkg::OP_OR:   mid_nxt.logic_res = a8 | b8;
      cpu8alu_pkg::OP_SWAP: mid_nxt.logic_res = {a8[3:0], a8[7:4]};
      cpu8alu_pkg::OP_ADD16: begin
        y_lo         = b8;
        mid_nxt.x_hi = in1_r.operand_a[15:8];
        mid_nxt.y_hi = in1_r.operand_b[15:8];
      end
      default: begin
        x_lo = 8'h00;
      end
    endcase

    nib                = {1'b0, x_lo[3:0]} + {1'b0, y_lo[3:0]} + {4'd0, ci};
    mid_nxt.h4         = nib[4];
    mid_nxt.sum_lo     = {1'b0, x_lo} + {1'b0, y_lo} + {8'd0, ci};
    mid_nxt.operation  = in1_r.operation;
    mid_nxt.flags_in   = in1_r.flags_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    mid_r <= mid_nxt;
  end

  // Stage 3: high-byte add, flag assembly
  always_comb begin
    logic [8:0] hi;
    logic [4:0] nib12;
    logic [7:0] r8;
    logic       zr;
    logic       zl;
    logic       cin;

    hi    = {1'b0, mid_r.x_hi} + {1'b0, mid_r.y_hi} + {8'd0, mid_r.sum_lo[8]};
    nib12 = {1'b0, mid_r.x_hi[3:0]} + {1'b0, mid_r.y_hi[3:0]} + {4'd0, mid_r.sum_lo[8]};
    r8    = mid_r.sum_lo[7:0];
    zr    = (r8 == 8'h00);
    zl    = (mid_r.logic_res == 8'h00);
    cin   = mid_r.flags_in[cpu8alu_pkg::FLAG_C];

    out_item_nxt.result        = {8'h00, r8};
    out_item_nxt.flags_out     = 4'h0;
    out_item_nxt.writes_result = 1'b1;

    case (mid_r.operation)
      cpu8alu_pkg::OP_ADD, cpu8alu_pkg::OP_ADC: begin
        out_item_nxt.flags_out = {zr, 1'b0, mid_r.h4, mid_r.sum_lo[8]};
      end
      cpu8alu_pkg::OP_SUB, cpu8alu_pkg::OP_SBC: begin
        out_item_nxt.flags_out = {zr, 1'b1, ~mid_r.h4, ~mid_r.sum_lo[8]};
      end
      cpu8alu_pkg::OP_CP: begin
        out_item_nxt.flags_out     = {zr, 1'b1, ~mid_r.h4, ~mid_r.sum_lo[8]};
        out_item_nxt.writes_result = 1'b0;
      end
      cpu8alu_pkg::OP_AND: begin
        out_item_nxt.result    = {8'h00, mid_r.logic_res};
        out_item_nxt.flags_out = {zl, 1'b0, 1'b1, 1'b0};
      end
      cpu8alu_pkg::OP_XOR, cpu8alu_pkg::OP_OR, cpu8alu_pkg::OP_SWAP: begin
        out_item_nxt.result    = {8'h00, mid_r.logic_res};
        out_item_nxt.flags_out = {zl, 3'b000};
      end
      cpu8alu_pkg::OP_INC: begin
        out_item_nxt.flags_out = {zr, 1'b0, mid_r.h4, cin};
      end
      cpu8alu_pkg::OP_DEC: begin
        out_item_nxt.flags_out = {zr, 1'b1, ~mid_r.h4, cin};
      end
      cpu8alu_pkg::OP_ADD16: begin
        out_item_nxt.result    = {hi[7:0], r8};
        out_item_nxt.flags_out = {mid_r.flags_in[cpu8alu_pkg::FLAG_Z], 1'b0,
                                  nib12[4], hi[8]};
      end
      default: begin
        out_item_nxt.result        = 16'h0000;
        out_item_nxt.flags_out     = mid_r.flags_in;
        out_item_nxt.writes_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/cpu8alu_chk.sv =====
// Port-level checker for cpu8_alu_with_flags, bound to the top level.
// Depends on cpu8alu_pkg for payload structs, opcodes and latency.

module cpu8alu_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input cpu8alu_pkg::alu_in_t  in_item,
  input logic                  out_valid,
  input cpu8alu_pkg::alu_out_t out_item
);

  // Every transfer in comes out after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(cpu8alu_pkg::LATENCY) out_valid)
    else $error("accepted command produced no result");

  // No result without a matching transfer in
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, cpu8alu_pkg::LATENCY))
    else $error("result strobe without a command");

  // Only compare and unused codes suppress writeback
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.writes_result) |->
      ($past(in_item.operation, cpu8alu_pkg::LATENCY) == cpu8alu_pkg::OP_CP ||
       $past(in_item.operation, cpu8alu_pkg::LATENCY) > cpu8alu_pkg::OP_ADD16))
    else $error("writeback dropped on a writing operation");

  // Byte-wide operations leave the high byte clear
  a_hi_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid &&
     $past(in_item.operation, cpu8alu_pkg::LATENCY) != cpu8alu_pkg::OP_ADD16) |->
      (out_item.result[15:8] == 8'h00))
    else $error("high byte set on an 8-bit operation");

endmodule

bind cpu8_alu_with_flags cpu8alu_chk u_cpu8alu_chk (.*);
